>>> rtl/core/priority_task_queue_macros.svh
// Assertion macros for the priority task queue.
// Included by the RTL modules that carry concurrent assertions; needs clk_i and rst_ni.
`ifndef PRIORITY_TASK_QUEUE_MACROS_SVH
`define PRIORITY_TASK_QUEUE_MACROS_SVH

// Checked at every rising edge, switched off while reset is asserted.
`define PTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PTQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/ptq_pkg.sv
// Package for the priority task queue: sizes, codes, payload and cell types.
// Used by ptq_slot_alloc, ptq_cell and priority_task_queue; depends on nothing.
package ptq_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  typedef enum logic [1:0] {
    CMD_CREATE   = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_PREEMPT  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_EMPTY      = 3'd2,
    STAT_NOT_READY  = 3'd3,
    STAT_NO_CURRENT = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    TS_DEAD        = 2'd0,
    TS_READY       = 2'd1,
    TS_RUNNING     = 2'd2,
    TS_INTERRUPTED = 2'd3
  } task_state_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2,
    CELL_MARK   = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  prio;
    logic [31:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] task_handle;
    logic [7:0]  task_prio;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        prio;
    logic [31:0]       handle;
    task_state_e       state;
  } entry_t;

  localparam entry_t ENTRY_NONE = '{
    valid: 1'b0, slot: '0, prio: 8'd0, handle: 32'd0, state: TS_DEAD
  };

  // Broadcast to every cell of the order list.
  typedef struct packed {
    cell_op_e          op;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        prio;
    logic [31:0]       handle;
    task_state_e       mark_state;
  } cell_ctrl_t;

  typedef struct packed {
    logic              take;
    logic              give_back;
    logic [SLOT_W-1:0] rel_slot;
  } alloc_req_t;

  // Result slot field is four bits wide; wider slot numbers wrap.
  function automatic logic [3:0] to_slot_field(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+3:0] t;
    t = {4'd0, s};
    return t[3:0];
  endfunction

endpackage

>>> rtl/core/ptq_slot_alloc.sv
// Slot occupancy flags and lowest-free-slot search for the priority task queue.
// Depends on ptq_pkg.
module ptq_slot_alloc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ptq_pkg::alloc_req_t        req_i,
  output logic [ptq_pkg::SLOT_W-1:0] free_slot_o
);

  logic [ptq_pkg::TASK_SLOTS-1:0] used_q, used_d;

  // Priority encoder: the lowest clear bit wins, as the search runs downwards.
  always_comb begin
    free_slot_o = '0;
    for (int i = ptq_pkg::TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_slot_o = ptq_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    used_d = used_q;
    if (req_i.take) begin
      used_d[free_slot_o] = 1'b1;
    end
    if (req_i.give_back) begin
      used_d[req_i.rel_slot] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

endmodule

>>> rtl/core/ptq_cell.sv
// One cell of the ordered task list: holds one entry and trades with its neighbours.
// Depends on ptq_pkg.
module ptq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptq_pkg::cell_ctrl_t ctrl_i,
  input  ptq_pkg::entry_t     left_i,
  input  logic                left_le_i,
  input  ptq_pkg::entry_t     right_i,
  output ptq_pkg::entry_t     entry_o,
  output logic                le_o
);

  ptq_pkg::entry_t entry_q, entry_d;

  // True when this entry stays ahead of a task being created.
  assign le_o    = entry_q.valid && (entry_q.prio <= ctrl_i.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      ptq_pkg::CELL_INSERT: begin
        if (!le_o) begin
          if (left_le_i) begin
            entry_d.valid  = 1'b1;
            entry_d.slot   = ctrl_i.slot;
            entry_d.prio   = ctrl_i.prio;
            entry_d.handle = ctrl_i.handle;
            entry_d.state  = ptq_pkg::TS_READY;
          end else begin
            entry_d = left_i;
          end
        end
      end
      ptq_pkg::CELL_POP: begin
        entry_d = right_i;
      end
      ptq_pkg::CELL_MARK: begin
        if (entry_q.valid && (entry_q.slot == ctrl_i.slot)) begin
          entry_d.state = ctrl_i.mark_state;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= ptq_pkg::ENTRY_NONE;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

>>> rtl/core/priority_task_queue.sv
// Top level of the priority task queue: command decode, cell chain and result register.
// Depends on ptq_pkg, ptq_cell, ptq_slot_alloc and priority_task_queue_macros.svh.
//
//   Channel   Signals                               Direction   Moves
//   in        in_valid_i, in_stall_o, in_data_i     into block  one command per transfer
//   out       out_valid_o, out_stall_i, out_data_o  out of block one result per transfer
//
// Every command is decoded against the cell chain; the cells and the result register
// are loaded at the same edge, so a new command may follow in the next cycle unless
// the input is stalled. The compare-and-shift cells insert or pop in one step.
// Reset clears the list, the slot flags and the current task; no clearing pass is needed.
// The input is stalled only while a result waits in the output register and the output
// side stalls; a result that is taken in the same cycle frees the register for the next.

`include "priority_task_queue_macros.svh"

module priority_task_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptq_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptq_pkg::out_item_t out_data_o
);

  localparam int N = ptq_pkg::TASK_SLOTS;

  // The cell chain. Cell 0 is the head of the list.
  ptq_pkg::entry_t     ent [N];
  logic [N-1:0]        le;
  logic [N-1:0]        cell_valid;
  ptq_pkg::cell_ctrl_t ctrl;

  // Book-keeping registers.
  logic [ptq_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       cur_valid_q, cur_valid_d;
  logic [ptq_pkg::SLOT_W-1:0] cur_slot_q, cur_slot_d;
  logic [7:0]                 cur_prio_q, cur_prio_d;

  // Result register.
  logic               out_valid_q, out_valid_d;
  ptq_pkg::out_item_t out_q, res;

  ptq_pkg::alloc_req_t        alloc_req;
  logic [ptq_pkg::SLOT_W-1:0] free_slot;
  logic                       in_accept;
  ptq_pkg::entry_t            head;

  // A waiting result holds back the input only if it is not taken in this cycle.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign head        = ent[0];

  ptq_slot_alloc u_alloc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (alloc_req),
    .free_slot_o (free_slot)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    ptq_pkg::entry_t left_e, right_e;
    logic            left_le;

    if (i == 0) begin : g_first
      assign left_e  = ptq_pkg::ENTRY_NONE;
      assign left_le = 1'b1;
    end else begin : g_inner_left
      assign left_e  = ent[i-1];
      assign left_le = le[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_e = ptq_pkg::ENTRY_NONE;
    end else begin : g_inner_right
      assign right_e = ent[i+1];
    end

    ptq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_e),
      .left_le_i (left_le),
      .right_i   (right_e),
      .entry_o   (ent[i]),
      .le_o      (le[i])
    );

    assign cell_valid[i] = ent[i].valid;
  end

  // Command decode. Everything below only takes effect on an accepted transfer.
  always_comb begin
    res             = '0;
    ctrl.op         = ptq_pkg::CELL_HOLD;
    ctrl.slot       = free_slot;
    ctrl.prio       = in_data_i.prio;
    ctrl.handle     = in_data_i.handle;
    ctrl.mark_state = ptq_pkg::TS_RUNNING;
    alloc_req       = '0;
    alloc_req.rel_slot = head.slot;
    count_d         = count_q;
    cur_valid_d     = cur_valid_q;
    cur_slot_d      = cur_slot_q;
    cur_prio_d      = cur_prio_q;

    case (ptq_pkg::cmd_e'(in_data_i.cmd))
      ptq_pkg::CMD_CREATE: begin
        if (count_q == ptq_pkg::CNT_W'(N)) begin
          res.status = ptq_pkg::STAT_FULL;
        end else begin
          res.status     = ptq_pkg::STAT_OK;
          res.slot       = ptq_pkg::to_slot_field(free_slot);
          res.task_prio  = in_data_i.prio;
          ctrl.op        = ptq_pkg::CELL_INSERT;
          alloc_req.take = 1'b1;
          count_d        = count_q + ptq_pkg::CNT_W'(1);
        end
      end
      ptq_pkg::CMD_PREEMPT: begin
        if (!cur_valid_q) begin
          res.status = ptq_pkg::STAT_NO_CURRENT;
        end else begin
          // The current task may have been overtaken by a newer head.
          res.status      = ptq_pkg::STAT_OK;
          res.slot        = ptq_pkg::to_slot_field(cur_slot_q);
          res.task_prio   = cur_prio_q;
          ctrl.op         = ptq_pkg::CELL_MARK;
          ctrl.slot       = cur_slot_q;
          ctrl.mark_state = ptq_pkg::TS_INTERRUPTED;
        end
      end
      ptq_pkg::CMD_DISPATCH: begin
        if (count_q == '0) begin
          res.status = ptq_pkg::STAT_EMPTY;
        end else if (head.state != ptq_pkg::TS_READY) begin
          res.status    = ptq_pkg::STAT_NOT_READY;
          res.slot      = ptq_pkg::to_slot_field(head.slot);
          res.task_prio = head.prio;
        end else begin
          res.status      = ptq_pkg::STAT_OK;
          res.slot        = ptq_pkg::to_slot_field(head.slot);
          res.task_handle = head.handle;
          res.task_prio   = head.prio;
          ctrl.op         = ptq_pkg::CELL_MARK;
          ctrl.slot       = head.slot;
          ctrl.mark_state = ptq_pkg::TS_RUNNING;
          cur_valid_d     = 1'b1;
          cur_slot_d      = head.slot;
          cur_prio_d      = head.prio;
        end
      end
      ptq_pkg::CMD_COMPLETE: begin
        if (count_q == '0) begin
          res.status = ptq_pkg::STAT_EMPTY;
        end else begin
          // The head is freed whatever its state.
          res.status          = ptq_pkg::STAT_OK;
          res.slot            = ptq_pkg::to_slot_field(head.slot);
          res.task_prio       = head.prio;
          ctrl.op             = ptq_pkg::CELL_POP;
          alloc_req.give_back = 1'b1;
          count_d             = count_q - ptq_pkg::CNT_W'(1);
          cur_valid_d         = 1'b0;
        end
      end
      default: begin
        res.status = ptq_pkg::STAT_OK;
      end
    endcase

    if (!in_accept) begin
      ctrl.op             = ptq_pkg::CELL_HOLD;
      alloc_req.take      = 1'b0;
      alloc_req.give_back = 1'b0;
      count_d             = count_q;
      cur_valid_d         = cur_valid_q;
      cur_slot_d          = cur_slot_q;
      cur_prio_d          = cur_prio_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cur_valid_q <= 1'b0;
      cur_slot_q  <= '0;
      cur_prio_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      cur_valid_q <= cur_valid_d;
      cur_slot_q  <= cur_slot_d;
      cur_prio_q  <= cur_prio_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= res;
    end
  end

  // The number of occupied cells must track the list length.
  `PTQ_ASSERT(a_count_matches_cells,
              ptq_pkg::CNT_W'($countones(cell_valid)) == count_q,
              "list length and occupied cells disagree")
  // The head cell is occupied exactly when the list is not empty.
  `PTQ_ASSERT(a_head_valid, (count_q != '0) == ent[0].valid,
              "head cell does not reflect list length")
  // A current task implies that the list is not empty.
  `PTQ_ASSERT(a_current_listed, cur_valid_q |-> (count_q != '0),
              "current task set on an empty list")
  // A completed head leaves no current task behind.
  `PTQ_ASSERT(a_complete_clears_current,
              (in_accept && (in_data_i.cmd == ptq_pkg::CMD_COMPLETE) && (count_q != '0))
              |=> !cur_valid_q,
              "current task survived a complete")

endmodule
